/* rtl/core/rfwa_pkg.sv */
`default_nettype none
package rfwa_pkg;

  // Window geometry
  localparam int MAX_WINDOW = 128;
  localparam int WIN_AW     = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int FILT_W   = 19;
  localparam int NORM_W   = 24;
  localparam int HELD_W   = 8;
  localparam int COEF_W   = 16;
  localparam int LOW_W    = 20;
  localparam int INV_W    = 40;
  localparam int LEN_W    = 8;

  // Arithmetic widths
  localparam int SUM_W     = 32;
  localparam int DIV_CNT_W = $clog2(SUM_W);
  localparam int MUL_W     = 21;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = 62;
  localparam int INV_SPLIT = INV_W / 2;
  localparam int COEF_ONE  = 32768;
  localparam int FB_SHIFT  = 15;
  localparam int NORM_SHIFT = 16;

  localparam logic [FILT_W-1:0] FB_MAX   = {FILT_W{1'b1}};
  localparam logic [NORM_W-1:0] NORM_MAX = {1'b0, {(NORM_W-1){1'b1}}};
  localparam logic [NORM_W-1:0] NORM_MIN = {1'b1, {(NORM_W-1){1'b0}}};

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_COUNT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEFFICIENT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_VALUE          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_RANGE      = 3'd4;

  localparam logic [LEN_W-1:0]  RST_WINDOW_LENGTH = 8'd100;
  localparam logic [LEN_W-1:0]  RST_AVERAGE_COUNT = 8'd0;
  localparam logic [COEF_W-1:0] RST_FILTER_COEF   = 16'h828F;  // -32113
  localparam logic [LOW_W-1:0]  RST_LOW_VALUE     = 20'd0;
  localparam logic [INV_W-1:0]  RST_INVERSE_RANGE = 40'h01_0000_0000;

  // Item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  // Multiplier operand selects
  localparam logic [1:0] MUL_X_A  = 2'd0;
  localparam logic [1:0] MUL_A_FB = 2'd1;
  localparam logic [1:0] MUL_D_LO = 2'd2;
  localparam logic [1:0] MUL_D_HI = 2'd3;

  // Window read address selects
  localparam logic RD_OLDEST = 1'b0;
  localparam logic RD_NEWEST = 1'b1;

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic        [FILT_W-1:0] filtered_value;
    logic signed [NORM_W-1:0] normalized_value;
    logic signed [NORM_W-1:0] window_average;
    logic        [HELD_W-1:0] held_count;
  } out_item_t;

  typedef struct packed {
    logic       clear;
    logic       load_in;
    logic [1:0] mul_sel;
    logic       acc_load;
    logic       acc_add;
    logic       acc_add_hi;
    logic       abs_load;
    logic       fb_load;
    logic       norm_load;
    logic       rd_sel;
    logic       evict;
    logic       push;
    logic       avg_setup;
    logic       ps_acc;
    logic       div_init;
    logic       div_step;
    logic       div_fin;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic over_limit;
    logic sum_all;
    logic ps_last;
  } dp_status_t;

endpackage
`default_nettype wire

/* rtl/core/rfwa_dp.sv */
`default_nettype none
module rfwa_dp import rfwa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_item_t              in_data,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  output out_item_t             out_data
);

  // configuration
  logic        [LEN_W-1:0]  win_len_r;
  logic        [LEN_W-1:0]  avg_cnt_r;
  logic signed [COEF_W-1:0] coef_r;
  logic signed [LOW_W-1:0]  low_r;
  logic        [INV_W-1:0]  inv_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r   <= RST_WINDOW_LENGTH;
      avg_cnt_r   <= RST_AVERAGE_COUNT;
      coef_r      <= RST_FILTER_COEF;
      low_r       <= RST_LOW_VALUE;
      inv_range_r <= RST_INVERSE_RANGE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_LENGTH:      win_len_r   <= cfg_data[LEN_W-1:0];
        CFG_AVERAGE_COUNT:      avg_cnt_r   <= cfg_data[LEN_W-1:0];
        CFG_FILTER_COEFFICIENT: coef_r      <= cfg_data[COEF_W-1:0];
        CFG_LOW_VALUE:          low_r       <= cfg_data[LOW_W-1:0];
        CFG_INVERSE_RANGE:      inv_range_r <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // filter / normalize datapath
  logic signed [SAMPLE_W-1:0] sample_r;
  logic        [FILT_W-1:0]   fb_r;
  logic signed [MUL_W-1:0]    coef_ext, diff, mul_a, mul_b;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic        [ACC_W-1:0]    mag_r;
  logic                       neg_r;
  logic        [ACC_W-1:0]    fb_rnd, nrm_rnd;
  logic signed [NORM_W-1:0]   norm_r, norm_nxt;
  logic        [FILT_W-1:0]   fb_nxt;

  assign coef_ext = MUL_W'(coef_r);
  assign diff     = $signed({2'b00, fb_r}) - MUL_W'(low_r);

  always_comb begin
    case (cmd.mul_sel)
      MUL_X_A: begin
        mul_a = MUL_W'(sample_r);
        mul_b = MUL_W'(COEF_ONE) - coef_ext;
      end
      MUL_A_FB: begin
        mul_a = coef_ext;
        mul_b = $signed({2'b00, fb_r});
      end
      MUL_D_LO: begin
        mul_a = diff;
        mul_b = $signed({1'b0, inv_range_r[INV_SPLIT-1:0]});
      end
      default: begin
        mul_a = diff;
        mul_b = $signed({1'b0, inv_range_r[INV_W-1:INV_SPLIT]});
      end
    endcase
  end

  // round half up, saturate to the feedback width
  assign fb_rnd = (mag_r + ACC_W'(1 << (FB_SHIFT - 1))) >> FB_SHIFT;
  assign fb_nxt = (fb_rnd > ACC_W'(FB_MAX)) ? FB_MAX : fb_rnd[FILT_W-1:0];

  // round half away from zero, saturate to Q8.16
  assign nrm_rnd = (mag_r + ACC_W'(1 << (NORM_SHIFT - 1))) >> NORM_SHIFT;
  always_comb begin
    if (neg_r) begin
      if (nrm_rnd > ACC_W'({1'b0, NORM_MIN})) norm_nxt = NORM_MIN;
      else norm_nxt = NORM_W'(~nrm_rnd[NORM_W-1:0] + NORM_W'(1));
    end else begin
      if (nrm_rnd > ACC_W'(NORM_MAX)) norm_nxt = NORM_MAX;
      else norm_nxt = nrm_rnd[NORM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (cmd.load_in) sample_r <= in_data.sample;
    if (cmd.acc_load) acc_r <= ACC_W'(prod_r);
    else if (cmd.acc_add) acc_r <= acc_r + ACC_W'(prod_r);
    else if (cmd.acc_add_hi) acc_r <= acc_r + (ACC_W'(prod_r) <<< INV_SPLIT);
    if (cmd.abs_load) begin
      mag_r <= acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
      neg_r <= acc_r[ACC_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fb_r <= '0;
    else if (cmd.fb_load) fb_r <= fb_nxt;
  end

  // window store and bookkeeping
  logic signed [NORM_W-1:0] win_mem [MAX_WINDOW];
  logic signed [NORM_W-1:0] rd_q;
  logic        [WIN_AW-1:0] rd_addr, wp_r, idx_r;
  logic        [CNT_W-1:0]  fill_r, total_r, limit, total;
  logic signed [SUM_W-1:0]  sum_r, ps_r;
  logic signed [NORM_W-1:0] avg_r;

  assign rd_addr = (cmd.rd_sel == RD_NEWEST) ? (wp_r - WIN_AW'(1) - idx_r)
                                              : (wp_r - fill_r[WIN_AW-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.push) win_mem[wp_r] <= norm_r;
    rd_q <= win_mem[rd_addr];
  end

  // zero reads as one, anything past the store as the store depth
  always_comb begin
    if (win_len_r == '0) limit = CNT_W'(1);
    else if (int'(win_len_r) > MAX_WINDOW) limit = CNT_W'(MAX_WINDOW);
    else limit = CNT_W'(win_len_r);
  end

  always_comb begin
    if (avg_cnt_r == '0 || int'(avg_cnt_r) > int'(fill_r)) total = fill_r;
    else total = CNT_W'(avg_cnt_r);
  end

  assign status.full       = (fill_r == CNT_W'(MAX_WINDOW));
  assign status.over_limit = (fill_r > limit);
  assign status.sum_all    = (total == fill_r);
  assign status.ps_last    = ((CNT_W'(idx_r) + CNT_W'(1)) == total_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else if (cmd.clear) begin
      wp_r   <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else if (cmd.evict) begin
      fill_r <= fill_r - CNT_W'(1);
      sum_r  <= sum_r - SUM_W'(rd_q);
    end else if (cmd.push) begin
      wp_r   <= wp_r + WIN_AW'(1);
      fill_r <= fill_r + CNT_W'(1);
      sum_r  <= sum_r + SUM_W'(norm_r);
    end
  end

  // newest-N sum and bit-serial divide
  logic [SUM_W-1:0] quo_r;
  logic [CNT_W-1:0] rem_r;
  logic [CNT_W:0]   rem_sh;
  logic             div_neg_r;

  assign rem_sh = {rem_r, quo_r[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      norm_r <= '0;
      avg_r  <= '0;
    end else begin
      if (cmd.norm_load) norm_r <= norm_nxt;
      // magnitude quotient, sign restored: truncates toward zero
      if (cmd.div_fin) avg_r <= div_neg_r ? NORM_W'(SUM_W'(0) - quo_r) : NORM_W'(quo_r);
    end
    if (cmd.avg_setup) begin
      total_r <= total;
      idx_r   <= '0;
      ps_r    <= status.sum_all ? sum_r : '0;
    end else if (cmd.ps_acc) begin
      idx_r <= idx_r + WIN_AW'(1);
      ps_r  <= ps_r + SUM_W'(rd_q);
    end
    if (cmd.div_init) begin
      div_neg_r <= ps_r[SUM_W-1];
      quo_r     <= ps_r[SUM_W-1] ? SUM_W'(-ps_r) : SUM_W'(ps_r);
      rem_r     <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, total_r}) begin
        rem_r <= CNT_W'(rem_sh - {1'b0, total_r});
        quo_r <= {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[CNT_W-1:0];
        quo_r <= {quo_r[SUM_W-2:0], 1'b0};
      end
    end
  end

  // result register
  out_item_t out_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.filtered_value   <= (fill_r > CNT_W'(1)) ? fb_r : '0;
      out_r.normalized_value <= norm_r;
      out_r.window_average   <= avg_r;
      out_r.held_count       <= HELD_W'(fill_r);
    end
  end

  assign out_data = out_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fill_r) <= MAX_WINDOW)
    else $error("window fill count beyond store depth");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_init |-> total_r != '0)
    else $error("divide started with zero count");

endmodule
`default_nettype wire

/* rtl/core/rfwa_ctrl.sv */
`default_nettype none
module rfwa_ctrl import rfwa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_kind,
  input  logic       out_ready,
  input  dp_status_t status,
  output logic       in_ready,
  output logic       out_valid,
  output dp_cmd_t    cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_M0     = 5'd1;
  localparam logic [4:0] S_M1     = 5'd2;
  localparam logic [4:0] S_M2     = 5'd3;
  localparam logic [4:0] S_ABS1   = 5'd4;
  localparam logic [4:0] S_FB     = 5'd5;
  localparam logic [4:0] S_M3     = 5'd6;
  localparam logic [4:0] S_M4     = 5'd7;
  localparam logic [4:0] S_M5     = 5'd8;
  localparam logic [4:0] S_ABS2   = 5'd9;
  localparam logic [4:0] S_NORM   = 5'd10;
  localparam logic [4:0] S_CHK    = 5'd11;
  localparam logic [4:0] S_RD_EV  = 5'd12;
  localparam logic [4:0] S_SUB_EV = 5'd13;
  localparam logic [4:0] S_WRITE  = 5'd14;
  localparam logic [4:0] S_TRIM   = 5'd15;
  localparam logic [4:0] S_RD_TR  = 5'd16;
  localparam logic [4:0] S_SUB_TR = 5'd17;
  localparam logic [4:0] S_AVG    = 5'd18;
  localparam logic [4:0] S_RD_PS  = 5'd19;
  localparam logic [4:0] S_ACC_PS = 5'd20;
  localparam logic [4:0] S_DIVI   = 5'd21;
  localparam logic [4:0] S_DIV    = 5'd22;
  localparam logic [4:0] S_DFIN   = 5'd23;
  localparam logic [4:0] S_DONE   = 5'd24;

  logic [4:0]           state_r, state_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (in_kind == KIND_CLEAR) begin
            cmd.clear = 1'b1;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_M0;
          end
        end
      end
      S_M0: begin
        cmd.mul_sel = MUL_X_A;
        state_nxt   = S_M1;
      end
      S_M1: begin
        cmd.mul_sel  = MUL_A_FB;
        cmd.acc_load = 1'b1;
        state_nxt    = S_M2;
      end
      S_M2: begin
        cmd.acc_add = 1'b1;
        state_nxt   = S_ABS1;
      end
      S_ABS1: begin
        cmd.abs_load = 1'b1;
        state_nxt    = S_FB;
      end
      S_FB: begin
        cmd.fb_load = 1'b1;
        state_nxt   = S_M3;
      end
      S_M3: begin
        cmd.mul_sel = MUL_D_LO;
        state_nxt   = S_M4;
      end
      S_M4: begin
        cmd.mul_sel  = MUL_D_HI;
        cmd.acc_load = 1'b1;
        state_nxt    = S_M5;
      end
      S_M5: begin
        cmd.acc_add_hi = 1'b1;
        state_nxt      = S_ABS2;
      end
      S_ABS2: begin
        cmd.abs_load = 1'b1;
        state_nxt    = S_NORM;
      end
      S_NORM: begin
        cmd.norm_load = 1'b1;
        state_nxt     = S_CHK;
      end
      S_CHK: begin
        state_nxt = status.full ? S_RD_EV : S_WRITE;
      end
      S_RD_EV: begin
        cmd.rd_sel = RD_OLDEST;
        state_nxt  = S_SUB_EV;
      end
      S_SUB_EV: begin
        cmd.evict = 1'b1;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.push  = 1'b1;
        state_nxt = S_TRIM;
      end
      S_TRIM: begin
        state_nxt = status.over_limit ? S_RD_TR : S_AVG;
      end
      S_RD_TR: begin
        cmd.rd_sel = RD_OLDEST;
        state_nxt  = S_SUB_TR;
      end
      S_SUB_TR: begin
        cmd.evict = 1'b1;
        state_nxt = S_TRIM;
      end
      S_AVG: begin
        cmd.avg_setup = 1'b1;
        state_nxt     = status.sum_all ? S_DIVI : S_RD_PS;
      end
      S_RD_PS: begin
        cmd.rd_sel = RD_NEWEST;
        state_nxt  = S_ACC_PS;
      end
      S_ACC_PS: begin
        cmd.ps_acc = 1'b1;
        state_nxt  = status.ps_last ? S_DIVI : S_RD_PS;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        div_cnt_nxt  = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt_r == DIV_CNT_W'(SUM_W - 1)) state_nxt = S_DFIN;
        else div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
      end
      S_DFIN: begin
        cmd.div_fin = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register loaded while an item is pending");

  a_trim_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_AVG |-> !status.over_limit)
    else $error("averaging started with window over its length");

  a_room_on_push: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WRITE |-> !status.full)
    else $error("push into a full window");

endmodule
`default_nettype wire

/* rtl/core/rectified_filter_window_average_unit.sv */
`default_nettype none
// Channel   Dir  Handshake            Payload
// in_*      in   in_valid/in_ready    in_item_t {kind, sample}
// out_*     out  out_valid/out_ready  out_item_t {filtered, normalized, average, held}
// cfg_*     in   cfg_we (no wait)     cfg_index, cfg_data
//
// Sample item, accept to result: accept, filter and normalize (one shared 21x21
// multiplier, four products), window update, mean (32-step bit-serial divide). Each
// value dropped from the window adds a read and subtract, each entry summed when
// average_count selects fewer than all held values a read and add.
// Sync reset; window RAM not cleared, the fill count guards it, so no sweep.
// A result waits in the output reg while the next item runs; a second one stalls.
module rectified_filter_window_average_unit import rfwa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t    cmd;     // controller -> datapath strobes
  dp_status_t status;  // datapath -> controller flags

  // sequencer: one item at a time through filter, window and divide
  rfwa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .out_ready (out_ready),
    .status    (status),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // config registers, multiplier, window RAM, running sum, divider, result reg
  rfwa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
